@@ rtl/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg: shared types and constants
// Payload structs, controller/datapath command and status, mask range table.
// ----------------------------------------------------------------------------
package cbe_pkg;

	localparam int STACK_DEPTH = 3;
	localparam int PC_W        = 11;

	localparam logic [4:0] CLS_MISC = 5'b01110;
	localparam logic [4:0] CLS_FLAG = 5'b01100;

	localparam logic [3:0] MISC_LOAD_Y   = 4'd0;
	localparam logic [3:0] MISC_BANK_Q   = 4'd1;
	localparam logic [3:0] MISC_JMP_R5   = 4'd2;
	localparam logic [3:0] MISC_RET      = 4'd3;
	localparam logic [3:0] MISC_STORE_X  = 4'd4;
	localparam logic [3:0] MISC_LOAD_X   = 4'd5;
	localparam logic [3:0] MISC_STORE_Y  = 4'd6;
	localparam logic [3:0] MISC_DISP     = 4'd7;
	localparam logic [3:0] MISC_HEX_OFF  = 4'd8;
	localparam logic [3:0] MISC_HEX_ON   = 4'd9;
	localparam logic [3:0] MISC_BANK_R5  = 4'd10;

	localparam logic [1:0] FLAG_SET    = 2'd0;
	localparam logic [1:0] FLAG_CLR    = 2'd1;
	localparam logic [1:0] FLAG_TEST   = 2'd2;
	localparam logic [1:0] FLAG_TOGGLE = 2'd3;

	localparam logic [2:0] SRC_ONE    = 3'd4;
	localparam logic [2:0] SRC_SHIFT  = 3'd5;
	localparam logic [2:0] SRC_R5_LO  = 3'd6;
	localparam logic [2:0] SRC_R5_ALL = 3'd7;

	localparam logic [1:0] DST_MOVE = 2'd3;

	localparam logic [12:0] COST_MASK  = 13'h0e07;
	localparam logic [5:0]  COST_DISP  = 6'd32;
	localparam logic [5:0]  COST_PLAIN = 6'd1;

	typedef struct packed {
		logic [12:0] opcode;
		logic        key_pressed;
		logic [3:0]  key_row;
		logic [2:0]  key_col;
	} in_item_t;

	typedef struct packed {
		logic [10:0] next_pc;
		logic        cond_flag;
		logic [1:0]  machine_mode;
		logic [7:0]  scratch_r5;
		logic        display_latched;
		logic [63:0] display_a;
		logic [63:0] display_b;
		logic [5:0]  cycle_cost;
	} out_item_t;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic digit_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_mask;
		logic last_digit;
	} sts_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] lo;
		logic [3:0] hi;
	} range_t;

	function automatic range_t mask_range(input logic [3:0] m);
		range_t r;
		r = '{ok: 1'b1, lo: 4'd0, hi: 4'd0};
		case (m)
			4'd0:  begin r.lo = 4'd12; r.hi = 4'd12; end
			4'd1:  begin r.lo = 4'd0;  r.hi = 4'd15; end
			4'd2:  begin r.lo = 4'd2;  r.hi = 4'd12; end
			4'd3:  begin r.lo = 4'd0;  r.hi = 4'd12; end
			4'd4:  begin r.lo = 4'd2;  r.hi = 4'd2;  end
			4'd5:  begin r.lo = 4'd0;  r.hi = 4'd1;  end
			4'd7:  begin r.lo = 4'd0;  r.hi = 4'd13; end
			4'd8:  begin r.lo = 4'd14; r.hi = 4'd14; end
			4'd9:  begin r.lo = 4'd13; r.hi = 4'd15; end
			4'd10: begin r.lo = 4'd14; r.hi = 4'd15; end
			4'd13: begin r.lo = 4'd13; r.hi = 4'd13; end
			4'd15: begin r.lo = 4'd15; r.hi = 4'd15; end
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/cbe_ifs.sv @@
// ----------------------------------------------------------------------------
// cbe channels
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface cbe_in_if;
	logic               valid;
	logic               ready;
	cbe_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cbe_out_if;
	logic               valid;
	logic               ready;
	cbe_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/calculator_bcd_cpu_execute_core.sv @@
// ----------------------------------------------------------------------------
// calculator_bcd_cpu_execute_core: calculator CPU execute unit
// Executes one 13-bit opcode per instruction beat, one result beat each.
// ----------------------------------------------------------------------------
// Branch, call, flag and miscellaneous opcodes pass from the idle state
// through the execute state to the done state, where their result is
// loaded into the output register. Masked digit operations also walk the
// digit state once per nibble from lo to hi, because the digit unit handles
// one nibble per cycle. The next beat is accepted once the block is back in
// the idle state after the load. The result sits in an output register, so a
// new beat is taken while the previous result waits; a second finished result
// holds the block until the first has been taken.
module calculator_bcd_cpu_execute_core #(
	parameter int STORE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	cbe_in_if.sink     in_ch,
	cbe_out_if.source  out_ch
);

	cbe_pkg::cmd_t cmd;
	cbe_pkg::sts_t sts;

	cbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbe_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_ch.data),
		.out_data (out_ch.data)
	);

endmodule

@@ rtl/cbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbe_ctrl: sequencer
// Accepts a beat, runs the execute step, walks the digit loop, loads the result.
// ----------------------------------------------------------------------------
module cbe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  cbe_pkg::sts_t sts,
	output cbe_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_DIGIT = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.latch_in   = (state_q == ST_IDLE) && in_valid;
		cmd.exec       = (state_q == ST_EXEC);
		cmd.digit_step = (state_q == ST_DIGIT);
		cmd.load_out   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= sts.is_mask ? ST_DIGIT : ST_DONE;
				end
				ST_DIGIT: begin
					if (sts.last_digit)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/cbe_dp.sv @@
// ----------------------------------------------------------------------------
// cbe_dp: execute datapath
// Register file, storage banks, return stack, digit-serial BCD/hex unit.
// ----------------------------------------------------------------------------
module cbe_dp #(
	parameter int STORE_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cbe_pkg::cmd_t      cmd,
	output cbe_pkg::sts_t      sts,
	input  cbe_pkg::in_item_t  in_data,
	output cbe_pkg::out_item_t out_data
);

	localparam int BW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [63:0] wr_q [4];
	logic [63:0] bx_q [STORE_DEPTH];
	logic [63:0] by_q [STORE_DEPTH];
	logic [10:0] stk_q [cbe_pkg::STACK_DEPTH];
	logic [10:0] pc_q;
	logic        cond_q, hex_q, latched_q;
	logic [7:0]  r5_q, cap_q;
	logic [2:0]  bank_q;
	logic [63:0] disp_a_q, disp_b_q;
	cbe_pkg::in_item_t  in_q;
	cbe_pkg::out_item_t out_q;
	logic [3:0]  dig_q, hold_q;
	logic        cy_q;

	logic [12:0] op;
	logic [1:0]  j, l;
	logic [2:0]  k;
	logic        n;
	cbe_pkg::range_t rng;
	logic [10:0] pc_inc;
	logic [BW-1:0] bi;
	logic [3:0]  bmod;

	assign op     = in_q.opcode;
	assign j      = op[7:6];
	assign k      = op[5:3];
	assign l      = op[2:1];
	assign n      = op[0];
	assign rng    = cbe_pkg::mask_range(op[11:8]);
	assign pc_inc = pc_q + 11'd1;

	always_comb begin
		bmod = {1'b0, bank_q};
		for (int t = 0; t < 8; t++)
			if (bmod >= 4'(STORE_DEPTH))
				bmod = bmod - 4'(STORE_DEPTH);
		bi = bmod[BW-1:0];
	end

	assign sts.is_mask = !op[12] && (op[11:8] != cbe_pkg::CLS_MISC[3:0])
		&& (op[11:8] != cbe_pkg::CLS_FLAG[3:0]) && rng.ok
		&& !(k == cbe_pkg::SRC_SHIFT && l == cbe_pkg::DST_MOVE);
	assign sts.last_digit = (dig_q == rng.hi);

	// digit unit
	logic [3:0] a, b, r0, nv, v, cv, nxt;
	logic [4:0] s5, t5;
	logic       base16, is_shift, is_arith, ge, lt, cy_n;
	logic       w1_en, w2_en;
	logic [1:0] w1_reg, w2_reg;
	logic [3:0] w1_val, w2_val;
	logic [7:0] cap_n;

	assign nxt      = dig_q + 4'd1;
	assign a        = wr_q[j][dig_q*4 +: 4];
	assign r0       = wr_q[0][dig_q*4 +: 4];
	assign base16   = (rng.lo >= 4'd13) || hex_q;
	assign is_shift = (k == cbe_pkg::SRC_SHIFT) && (l != cbe_pkg::DST_MOVE);
	assign is_arith = (k != cbe_pkg::SRC_SHIFT) && (l != cbe_pkg::DST_MOVE);

	always_comb begin
		b = 4'd0;
		if (!k[2])
			b = wr_q[k[1:0]][dig_q*4 +: 4];
		else if (k == cbe_pkg::SRC_ONE)
			b = (dig_q == rng.lo) ? 4'd1 : 4'd0;
		else if (k == cbe_pkg::SRC_R5_LO)
			b = (dig_q == rng.lo) ? r5_q[3:0] : 4'd0;
		else if (k == cbe_pkg::SRC_R5_ALL)
			b = (dig_q == rng.lo) ? r5_q[3:0] : ((dig_q == rng.lo + 4'd1) ? r5_q[7:4] : 4'd0);
	end

	always_comb begin
		s5 = {1'b0, a} + {1'b0, b} + {4'b0, cy_q};
		t5 = {1'b0, a} - {1'b0, b} - {4'b0, cy_q};
		lt = ({1'b0, a} < ({1'b0, b} + {4'b0, cy_q}));
		ge = base16 ? s5[4] : (s5 >= 5'd10);
		if (n) begin
			v    = lt ? (base16 ? t5[3:0] : t5[3:0] + 4'd10) : t5[3:0];
			cy_n = lt;
		end else begin
			v    = ge ? (base16 ? s5[3:0] : s5[3:0] - 4'd10) : s5[3:0];
			cy_n = ge;
		end
		if (n)
			nv = (dig_q != rng.hi) ? wr_q[j][nxt*4 +: 4] : 4'd0;
		else
			nv = (dig_q == rng.lo) ? 4'd0 : hold_q;
		w1_en = 1'b0; w1_reg = j; w1_val = v;
		w2_en = 1'b0; w2_reg = k[1:0]; w2_val = r0;
		cv = v;
		if (is_shift) begin
			w1_en = 1'b1; w1_val = nv; cv = nv;
		end else if (is_arith) begin
			if (l == 2'd0) begin
				w1_en = 1'b1;
			end else if (l == 2'd1 && !k[2]) begin
				w1_en = 1'b1; w1_reg = k[1:0];
			end
		end else if (n) begin
			w1_en = 1'b1; w1_val = b; cv = b;
		end else begin
			w1_en = 1'b1; w1_reg = 2'd0; w1_val = b;
			w2_en = !k[2]; cv = r0;
		end
		if (dig_q == rng.lo)
			cap_n = {4'd0, cv};
		else if (dig_q == rng.lo + 4'd1)
			cap_n = {cv, cap_q[3:0]};
		else
			cap_n = cap_q;
	end

	// flag op bit
	logic [5:0] fsh;
	assign fsh = {2'b11, op[5:2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) wr_q[r] <= '0;
			for (int r = 0; r < STORE_DEPTH; r++) begin
				bx_q[r] <= '0;
				by_q[r] <= '0;
			end
			for (int r = 0; r < cbe_pkg::STACK_DEPTH; r++) stk_q[r] <= '0;
			pc_q      <= '0;
			cond_q    <= 1'b0;
			hex_q     <= 1'b0;
			latched_q <= 1'b0;
			r5_q      <= '0;
			bank_q    <= '0;
			disp_a_q  <= '0;
			disp_b_q  <= '0;
		end else if (cmd.exec) begin
			latched_q <= 1'b0;
			pc_q      <= pc_inc;
			if (op[12:11] == 2'b11) begin
				if (op[10] == cond_q)
					pc_q <= {pc_inc[10], op[9:0]};
				cond_q <= 1'b0;
			end else if (op[12:11] == 2'b10) begin
				for (int r = cbe_pkg::STACK_DEPTH - 1; r > 0; r--) stk_q[r] <= stk_q[r-1];
				stk_q[0] <= pc_inc;
				pc_q     <= op[10:0];
				cond_q   <= 1'b0;
			end else if (op[12:8] == cbe_pkg::CLS_MISC) begin
				case (op[3:0])
					cbe_pkg::MISC_LOAD_Y:  wr_q[0] <= by_q[bi];
					cbe_pkg::MISC_BANK_Q:  bank_q <= op[6:4];
					cbe_pkg::MISC_JMP_R5:  pc_q <= {3'd0, r5_q};
					cbe_pkg::MISC_RET: begin
						cond_q <= 1'b0;
						pc_q   <= stk_q[0];
						for (int r = 0; r < cbe_pkg::STACK_DEPTH - 1; r++)
							stk_q[r] <= stk_q[r+1];
					end
					cbe_pkg::MISC_STORE_X: bx_q[bi] <= wr_q[0];
					cbe_pkg::MISC_LOAD_X:  wr_q[0] <= bx_q[bi];
					cbe_pkg::MISC_STORE_Y: by_q[bi] <= wr_q[0];
					cbe_pkg::MISC_DISP: begin
						if (in_q.key_pressed) begin
							r5_q   <= {1'b0, in_q.key_col, in_q.key_row - 4'd1};
							cond_q <= 1'b1;
						end
						disp_a_q  <= wr_q[0];
						disp_b_q  <= wr_q[1];
						latched_q <= 1'b1;
					end
					cbe_pkg::MISC_HEX_OFF: hex_q <= 1'b0;
					cbe_pkg::MISC_HEX_ON:  hex_q <= 1'b1;
					cbe_pkg::MISC_BANK_R5: bank_q <= r5_q[2:0];
					default: ;
				endcase
			end else if (op[12:8] == cbe_pkg::CLS_FLAG) begin
				case (op[1:0])
					cbe_pkg::FLAG_SET:  wr_q[j][fsh] <= 1'b1;
					cbe_pkg::FLAG_CLR:  wr_q[j][fsh] <= 1'b0;
					cbe_pkg::FLAG_TEST: if (wr_q[j][fsh]) cond_q <= 1'b1;
					default:            wr_q[j][fsh] <= ~wr_q[j][fsh];
				endcase
			end
		end else if (cmd.digit_step) begin
			if (w1_en) wr_q[w1_reg][dig_q*4 +: 4] <= w1_val;
			if (w2_en) wr_q[w2_reg][dig_q*4 +: 4] <= w2_val;
			if (sts.last_digit) begin
				r5_q <= cap_n;
				if (is_arith && cy_n)
					cond_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in)
			in_q <= in_data;
		if (cmd.exec) begin
			dig_q  <= rng.lo;
			cy_q   <= 1'b0;
			hold_q <= '0;
			cap_q  <= '0;
		end else if (cmd.digit_step) begin
			dig_q  <= nxt;
			cy_q   <= cy_n;
			hold_q <= a;
			cap_q  <= cap_n;
		end
		if (cmd.load_out) begin
			out_q.next_pc         <= pc_q;
			out_q.cond_flag       <= cond_q;
			out_q.machine_mode    <= wr_q[2][60] ? 2'd0 : ((wr_q[2][63:60] == 4'd8) ? 2'd1 : 2'd2);
			out_q.scratch_r5      <= r5_q;
			out_q.display_latched <= latched_q;
			out_q.display_a       <= disp_a_q;
			out_q.display_b       <= disp_b_q;
			out_q.cycle_cost      <= ((op & cbe_pkg::COST_MASK) == cbe_pkg::COST_MASK)
				? cbe_pkg::COST_DISP : cbe_pkg::COST_PLAIN;
		end
	end

	assign out_data = out_q;

endmodule

@@ dv/tb_calculator_bcd_cpu_execute_core.sv @@
// ----------------------------------------------------------------------------
// tb_calculator_bcd_cpu_execute_core: execute unit testbench
// Drives opcode beats with random gaps and result back-pressure, keeps its own
// model of the calculator state and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_calculator_bcd_cpu_execute_core;

	localparam int CYCLE_LIMIT = 300000;
	localparam int BANK_N      = 8;

	logic clk;
	logic arst_n;
	cbe_in_if  in_ch ();
	cbe_out_if out_ch ();

	calculator_bcd_cpu_execute_core #(.STORE_DEPTH(BANK_N)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// calculator state as the block should hold it
	logic [63:0] regs [4];
	logic [63:0] bank_x [BANK_N];
	logic [63:0] bank_y [BANK_N];
	logic [10:0] ret_stack [cbe_pkg::STACK_DEPTH];
	logic [10:0] pc;
	logic        cond;
	logic [7:0]  r5;
	logic [2:0]  bank_sel;
	logic        hex_on;
	logic [63:0] disp_a, disp_b;

	cbe_pkg::out_item_t expected_results [$];
	int  mismatches;
	int  cycles;
	bit  calm;

	function automatic logic [7:0] range_r5(logic [3:0] d [6][16], int idx, int lo, int hi);
		logic [7:0] v;
		v = {4'h0, d[idx][lo]};
		if (hi > lo)
			v[7:4] = d[idx][lo + 1];
		return v;
	endfunction

	task automatic digit_op(logic [12:0] op);
		logic [3:0] d [6][16];
		cbe_pkg::range_t rg;
		int j, k, l, n, rk, dst, lo, hi, base, cy, a, b, v;
		logic [3:0] t;
		rg = cbe_pkg::mask_range(op[11:8]);
		j = int'(op[7:6]); k = int'(op[5:3]); l = int'(op[2:1]); n = int'(op[0]);
		if (!rg.ok || (k == cbe_pkg::SRC_SHIFT && l == cbe_pkg::DST_MOVE))
			return;
		lo = int'(rg.lo); hi = int'(rg.hi);
		for (int r = 0; r < 6; r++)
			for (int i = 0; i < 16; i++)
				d[r][i] = (r < 4) ? regs[r][4*i +: 4] : 4'h0;
		rk = (k < 4) ? k : 4;
		if (k == cbe_pkg::SRC_ONE)
			d[4][lo] = 4'h1;
		else if (k == cbe_pkg::SRC_R5_LO)
			d[4][lo] = r5[3:0];
		else if (k == cbe_pkg::SRC_R5_ALL) begin
			d[4][lo] = r5[3:0];
			if (hi > lo)
				d[4][lo + 1] = r5[7:4];
		end
		if (l != cbe_pkg::DST_MOVE && k == cbe_pkg::SRC_SHIFT) begin
			if (n != 0) begin
				for (int i = lo; i < hi; i++)
					d[j][i] = d[j][i + 1];
				d[j][hi] = 4'h0;
			end else begin
				for (int i = hi; i > lo; i--)
					d[j][i] = d[j][i - 1];
				d[j][lo] = 4'h0;
			end
			r5 = range_r5(d, j, lo, hi);
		end else if (l != cbe_pkg::DST_MOVE) begin
			base = (lo >= 13 || hex_on) ? 16 : 10;
			cy = 0;
			dst = (l == 0) ? j : ((l == 1 && k < 4) ? k : 5);
			for (int i = lo; i <= hi; i++) begin
				a = int'(d[j][i]); b = int'(d[rk][i]);
				if (n != 0) begin
					if (a >= b + cy) begin v = a - b - cy; cy = 0; end
					else begin v = base + a - b - cy; cy = 1; end
				end else begin
					v = a + b + cy;
					if (v >= base) begin v -= base; cy = 1; end
					else cy = 0;
				end
				d[dst][i] = v[3:0];
			end
			if (cy != 0)
				cond = 1'b1;
			r5 = range_r5(d, dst, lo, hi);
		end else if (n != 0) begin
			for (int i = lo; i <= hi; i++)
				d[j][i] = d[rk][i];
			r5 = range_r5(d, rk, lo, hi);
		end else begin
			for (int i = lo; i <= hi; i++) begin
				t = d[0][i]; d[0][i] = d[rk][i]; d[rk][i] = t;
			end
			r5 = range_r5(d, rk, lo, hi);
		end
		for (int r = 0; r < 4; r++)
			for (int i = 0; i < 16; i++)
				regs[r][4*i +: 4] = d[r][i];
	endtask

	task automatic execute_opcode(cbe_pkg::in_item_t it);
		cbe_pkg::out_item_t res;
		logic [12:0] op;
		logic [3:0] d15;
		int sh;
		op = it.opcode;
		res = '0;
		pc = pc + 11'd1;
		if (op[12:11] == 2'b11) begin
			if (op[10] == cond)
				pc = {pc[10], op[9:0]};
			cond = 1'b0;
		end else if (op[12:11] == 2'b10) begin
			for (int i = cbe_pkg::STACK_DEPTH - 1; i > 0; i--)
				ret_stack[i] = ret_stack[i - 1];
			ret_stack[0] = pc;
			pc = op[10:0];
			cond = 1'b0;
		end else if (op[12:8] == cbe_pkg::CLS_MISC) begin
			case (op[3:0])
				cbe_pkg::MISC_LOAD_Y:  regs[0] = bank_y[bank_sel % BANK_N];
				cbe_pkg::MISC_BANK_Q:  bank_sel = op[6:4];
				cbe_pkg::MISC_JMP_R5:  pc = {3'b000, r5};
				cbe_pkg::MISC_RET: begin
					cond = 1'b0;
					pc = ret_stack[0];
					for (int i = 0; i + 1 < cbe_pkg::STACK_DEPTH; i++)
						ret_stack[i] = ret_stack[i + 1];
				end
				cbe_pkg::MISC_STORE_X: bank_x[bank_sel % BANK_N] = regs[0];
				cbe_pkg::MISC_LOAD_X:  regs[0] = bank_x[bank_sel % BANK_N];
				cbe_pkg::MISC_STORE_Y: bank_y[bank_sel % BANK_N] = regs[0];
				cbe_pkg::MISC_DISP: begin
					if (it.key_pressed) begin
						r5 = {1'b0, it.key_col, it.key_row - 4'd1};
						cond = 1'b1;
					end
					disp_a = regs[0];
					disp_b = regs[1];
					res.display_latched = 1'b1;
				end
				cbe_pkg::MISC_HEX_OFF: hex_on = 1'b0;
				cbe_pkg::MISC_HEX_ON:  hex_on = 1'b1;
				cbe_pkg::MISC_BANK_R5: bank_sel = r5[2:0];
				default: ;
			endcase
		end else if (op[12:8] == cbe_pkg::CLS_FLAG) begin
			sh = 4 * (int'(op[5:4]) + 12) + int'(op[3:2]);
			case (op[1:0])
				cbe_pkg::FLAG_SET:  regs[op[7:6]][sh] = 1'b1;
				cbe_pkg::FLAG_CLR:  regs[op[7:6]][sh] = 1'b0;
				cbe_pkg::FLAG_TEST: if (regs[op[7:6]][sh]) cond = 1'b1;
				default:            regs[op[7:6]][sh] = ~regs[op[7:6]][sh];
			endcase
		end else if (!op[12]) begin
			digit_op(op);
		end
		d15 = regs[2][63:60];
		res.next_pc = pc;
		res.cond_flag = cond;
		res.machine_mode = d15[0] ? 2'd0 : ((d15 == 4'd8) ? 2'd1 : 2'd2);
		res.scratch_r5 = r5;
		res.display_a = disp_a;
		res.display_b = disp_b;
		res.cycle_cost = ((op & cbe_pkg::COST_MASK) == cbe_pkg::COST_MASK)
			? cbe_pkg::COST_DISP : cbe_pkg::COST_PLAIN;
		expected_results.push_back(res);
	endtask

	task automatic send_beat(logic [12:0] op, logic kp = 1'b1, logic [3:0] row = 4'd3,
			logic [2:0] col = 3'd2);
		cbe_pkg::in_item_t it;
		it = '{opcode: op, key_pressed: kp, key_row: row, key_col: col};
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		do @(posedge clk); while (!in_ch.ready);
		execute_opcode(it);
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	function automatic logic [12:0] mask_op(int m, int j, int k, int l, int n);
		return 13'((m << 8) | (j << 6) | (k << 3) | (l << 1) | n);
	endfunction

	task automatic test_control;
		send_beat(13'h1000 | 13'h123);
		send_beat(13'h1000 | 13'h7ff);
		send_beat(13'h1000 | 13'h000);
		send_beat(13'h1800 | 13'h3ff);
		send_beat(13'h1c00 | 13'h155);
		send_beat(13'h0e00 | cbe_pkg::MISC_RET);
		send_beat(13'h0e00 | cbe_pkg::MISC_RET);
		send_beat(13'h0e00 | cbe_pkg::MISC_RET);
		send_beat(13'h0e00 | cbe_pkg::MISC_RET);
	endtask

	task automatic test_misc_ops;
		send_beat(mask_op(1, 0, 4, 0, 1));
		send_beat(13'h0e00 | cbe_pkg::MISC_DISP, 1'b1, 4'd0, 3'd7);
		send_beat(13'h0e00 | cbe_pkg::MISC_DISP, 1'b1, 4'd15, 3'd0);
		for (int p = 0; p < 16; p++)
			send_beat(13'h0e00 | 13'(($urandom_range(0, 15) << 4) | p), 1'b0);
		send_beat(13'h0e00 | 13'hf0 | cbe_pkg::MISC_BANK_Q);
		send_beat(13'h0e00 | cbe_pkg::MISC_STORE_X);
		send_beat(13'h0e00 | cbe_pkg::MISC_STORE_Y);
		send_beat(13'h0e00 | cbe_pkg::MISC_LOAD_X);
	endtask

	task automatic test_flag_bits;
		for (int f = 0; f < 4; f++)
			send_beat(13'h0c00 | 13'(($urandom_range(0, 63) << 2) | f));
		send_beat(13'h0c00 | 13'h80 | 13'h30 | 13'hc | cbe_pkg::FLAG_SET);
		send_beat(13'h0c00 | 13'h80 | 13'h30 | 13'hc | cbe_pkg::FLAG_TEST);
	endtask

	task automatic test_digit_ops;
		send_beat(mask_op(1, 0, 0, 0, 1));
		send_beat(mask_op(1, 1, 0, 0, 0));
		send_beat(mask_op(1, 0, 1, 0, 0));
		send_beat(mask_op(3, 2, 7, 1, 0));
		send_beat(mask_op(5, 3, 6, 2, 1));
		send_beat(mask_op(1, 0, 5, 0, 0));
		send_beat(mask_op(9, 0, 5, 1, 1));
		send_beat(mask_op(7, 1, 5, 3, 0));
		send_beat(mask_op(2, 1, 2, 3, 0));
		send_beat(mask_op(10, 1, 3, 3, 1));
		send_beat(mask_op(6, 0, 1, 0, 0));
		send_beat(mask_op(11, 0, 1, 0, 0));
		send_beat(13'h0e00 | cbe_pkg::MISC_HEX_ON);
		send_beat(mask_op(1, 0, 4, 0, 0));
		send_beat(13'h0e00 | cbe_pkg::MISC_HEX_OFF);
	endtask

	task automatic test_random(int n);
		int sel;
		logic [12:0] op;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				op = mask_op($urandom_range(0, 15), $urandom_range(0, 3),
					$urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 1));
				if (op[11:8] == 4'd12 || op[11:8] == 4'd14)
					op[11:8] = 4'd1;
			end else if (sel < 60)
				op = 13'h0c00 | 13'($urandom_range(0, 255));
			else if (sel < 75)
				op = 13'h0e00 | 13'($urandom_range(0, 255));
			else if (sel < 83)
				op = 13'h1000 | 13'($urandom_range(0, 2047));
			else if (sel < 90)
				op = 13'h0e00 | cbe_pkg::MISC_RET;
			else
				op = 13'h1800 | 13'($urandom_range(0, 2047));
			send_beat(op, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
				3'($urandom_range(0, 7)));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", out_ch.data);
			end else begin
				if (out_ch.data.next_pc !== expected_results[0].next_pc
						|| out_ch.data.cond_flag !== expected_results[0].cond_flag
						|| out_ch.data.machine_mode !== expected_results[0].machine_mode
						|| out_ch.data.scratch_r5 !== expected_results[0].scratch_r5
						|| out_ch.data.display_latched !== expected_results[0].display_latched
						|| out_ch.data.display_a !== expected_results[0].display_a
						|| out_ch.data.display_b !== expected_results[0].display_b
						|| out_ch.data.cycle_cost !== expected_results[0].cycle_cost) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %p got %p", expected_results[0], out_ch.data);
				end
				void'(expected_results.pop_front());
			end
		end
		out_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("calculator_bcd_cpu_execute_core verification failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		calm = 1'b0;
		regs = '{default: '0};
		bank_x = '{default: '0};
		bank_y = '{default: '0};
		ret_stack = '{default: '0};
		pc = '0; cond = 1'b0; r5 = '0; bank_sel = '0; hex_on = 1'b0;
		disp_a = '0; disp_b = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_control;
		test_misc_ops;
		drain;
		test_flag_bits;
		test_digit_ops;
		test_random(150);
		calm = 1'b1;
		test_random(100);
		calm = 1'b0;
		drain;
		test_random(150);
		drain;
		if (mismatches == 0 && expected_results.size() == 0)
			$display("calculator_bcd_cpu_execute_core verification clean");
		else
			$display("calculator_bcd_cpu_execute_core verification failed");
		$finish;
	end

endmodule

@@ calculator_bcd_cpu_execute_core.f @@
rtl/cbe_pkg.sv
rtl/cbe_ifs.sv
rtl/cbe_ctrl.sv
rtl/cbe_dp.sv
rtl/calculator_bcd_cpu_execute_core.sv
dv/tb_calculator_bcd_cpu_execute_core.sv
